@@ hdl/fgts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fgts_pkg;

  localparam int unsigned SAMPLE_BITS_DEF  = 24;
  localparam int unsigned TANH_ENTRIES_DEF = 1024;
  localparam int unsigned SERIES_TERMS     = 13;

  // Operand and product width of the shared signed multiplier.
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 21;

  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned THR_W   = 21;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned VOL_W   = 17;
  localparam int unsigned MODE_W  = 2;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd8192;
  localparam logic [THR_W-1:0]   THR_RST   = 21'd141935;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd38824;
  localparam logic [VOL_W-1:0]   VOL_RST   = 17'd52429;
  localparam logic [VOL_W-1:0]   VOL_UNITY = 17'h10000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DRIVE_GAIN     = 3'd0,
    REG_GATE_THRESHOLD = 3'd1,
    REG_TONE_ALPHA     = 3'd2,
    REG_OUT_VOLUME     = 3'd3,
    REG_CHANNEL_MODE   = 3'd4
  } cfg_reg_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_LEFT  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_BOTH  = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    ST_F_SETUP,
    ST_F_DIV,
    ST_F_WRITE,
    ST_F_UPD,
    ST_IDLE,
    ST_GN,
    ST_POS,
    ST_IDX,
    ST_RD0,
    ST_RD1,
    ST_GATE,
    ST_MULG,
    ST_MULS,
    ST_FILT,
    ST_MULV,
    ST_OUT,
    ST_DONE
  } fgts_state_e;

  // Ratio between neighboring table points, exp(-16/N) in Q0.31, from a
  // truncated Taylor series. The argument is floor(2^35 / N).
  function automatic logic [31:0] exp_ratio(input logic [63:0] step);
    logic [63:0] term;
    logic [63:0] sum;
    term = 64'h8000_0000;
    sum  = 64'h8000_0000;
    for (int k = 1; k < SERIES_TERMS; k++) begin
      term = ((term * step) >> 31) / 64'(k);
      if ((k % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum[31:0];
  endfunction

endpackage

`default_nettype wire

@@ hdl/fgts_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fgts_ram #(
  parameter int unsigned WIDTH = 23,
  parameter int unsigned DEPTH = 1025
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/fuzz_gate_tone_stereo_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Stereo fuzz stage: drive gain, tanh soft clip with noise gate, one-pole
// lowpass tone filter and output volume, one stereo frame per word.
// The input stream carries one frame per word (left sample in the low bits,
// right sample above it); the output stream returns one processed frame per
// accepted input word. Registers are written through the plain write port
// and must only change while no frame is in flight.
// After reset the block builds its tanh table in a RAM: one restoring
// division and one multiply per entry. During that sweep s_axis_tready_o
// is low; register writes are taken as usual. Reset also clears both
// lowpass states.
// All products go through one registered 33x33 signed multiplier, and each
// channel walks eleven sequencer steps around it; in stereo mode the left
// channel runs first, then the right. Ready returns in the same cycle that
// the output word turns valid. The result sits in an output register; while
// the receiver stalls, a finished frame waits in the last step and no new
// input word is accepted until the register frees up.
module fuzz_gate_tone_stereo_unit
  import fgts_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS        = SAMPLE_BITS_DEF,
  parameter int unsigned TANH_TABLE_ENTRIES = TANH_ENTRIES_DEF
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // Fields from bit 0 up: left_in, right_in, zero padding.
  input  wire [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire                                      m_axis_tready_i,
  // Fields from bit 0 up: left_out, right_out, zero padding.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       m_axis_tdata_o,
  input  wire                                      cfg_we_i,
  input  wire [CFG_INDEX_W-1:0]                    cfg_index_i,
  input  wire [CFG_DATA_W-1:0]                     cfg_wdata_i
);

  localparam int unsigned SB       = SAMPLE_BITS;
  localparam int unsigned TW       = SAMPLE_BITS - 1;
  localparam int unsigned EB       = 32 - SAMPLE_BITS;
  localparam int unsigned DEPTH    = TANH_TABLE_ENTRIES + 1;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned DATA_W   = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_W    = $clog2(TW);
  localparam int unsigned FRAC_LSB = SAMPLE_BITS - 4;
  localparam int unsigned IDX_LSB  = SAMPLE_BITS + 12;
  localparam logic [63:0] SeriesStep = (64'd16 << 31) / TANH_TABLE_ENTRIES;
  localparam logic [31:0] ExpRatio   = exp_ratio(SeriesStep);
  localparam logic [AW-1:0] LastAddr = AW'(TANH_TABLE_ENTRIES);

  // Configuration registers.
  logic [GAIN_W-1:0]  cfg_gain_q;
  logic [THR_W-1:0]   cfg_thr_q;
  logic [ALPHA_W-1:0] cfg_alpha_q;
  logic [VOL_W-1:0]   cfg_vol_q;
  logic [MODE_W-1:0]  cfg_mode_q;

  // Sequencer and control state.
  fgts_state_e       state_q, state_d;
  logic              ch_q, ch_d;
  logic [MODE_W-1:0] mode_q, mode_d;
  logic [AW-1:0]     fill_idx_q, fill_idx_d;
  logic [31:0]       q_q, q_d;
  logic [CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic              m_tvalid_q, m_tvalid_d;
  logic signed [31:0] tone_q [2];
  logic signed [31:0] tone_d [2];

  // Datapath registers.
  logic [32:0]              rem_q, rem_d;
  logic [32:0]              den_q, den_d;
  logic [TW-1:0]            quo_q, quo_d;
  logic [SB-1:0]            x_q [2];
  logic [SB-1:0]            x_d [2];
  logic [AW-1:0]            idx_q, idx_d;
  logic [15:0]              frac_q, frac_d;
  logic                     sat_q, sat_d;
  logic [TW-1:0]            t0_q, t0_d;
  logic signed [31:0]       g_q, g_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic [SB-1:0]            res_q [2];
  logic [SB-1:0]            res_d [2];
  logic [DATA_W-1:0]        m_tdata_q, m_tdata_d;
  logic signed [PROD_W-1:0] prod_q;

  // Shared multiplier operands.
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;

  // Table RAM ports.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [TW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [TW-1:0] ram_rdata;

  logic                     s_ready;
  logic                     out_load;
  logic [32:0]              rem_sh;
  logic                     div_ge;
  logic [SB-1:0]            x_cur;
  logic [SB-1:0]            x_abs;
  logic [PROD_W-1:0]        pos_u;
  logic [PROD_W-1:0]        pos_int;
  logic                     pos_sat;
  logic [TW-1:0]            tap_diff;
  logic [TW-1:0]            mag;
  logic                     gate_open;
  logic [31:0]              g_mag;
  logic signed [31:0]       g_val;
  logic [VOL_W-1:0]         vol_eff;
  logic [VOL_W-1:0]         alpha_c;
  logic signed [PROD_W-1:0] filt_sum;

  fgts_ram #(
    .WIDTH (TW),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Restoring division step used while the table is built.
  assign rem_sh = {rem_q[31:0], 1'b0};
  assign div_ge = (rem_sh >= den_q);

  // Table position: |x| * (gain * N), with SAMPLE_BITS+12 fraction bits.
  assign x_cur   = x_q[ch_q];
  assign x_abs   = x_cur[SB-1] ? (~x_cur + 1'b1) : x_cur;
  assign pos_u   = prod_q;
  assign pos_int = pos_u >> IDX_LSB;
  assign pos_sat = (pos_int >= PROD_W'(TANH_TABLE_ENTRIES));

  // Interpolation, gate and sign.
  assign tap_diff  = ram_rdata - t0_q;
  assign mag       = t0_q + prod_q[16 +: TW];
  assign gate_open = ({{(32-TW){1'b0}}, mag} >= {{(32-THR_W){1'b0}}, cfg_thr_q});
  assign g_mag     = gate_open ? ({{(32-TW){1'b0}}, mag} << EB) : 32'd0;
  assign g_val     = x_cur[SB-1] ? -$signed(g_mag) : $signed(g_mag);

  // Lowpass and volume terms.
  assign alpha_c  = VOL_UNITY - {1'b0, cfg_alpha_q};
  assign vol_eff  = cfg_vol_q[VOL_W-1] ? VOL_UNITY : cfg_vol_q;
  assign filt_sum = acc_q + prod_q;

  always_comb begin
    state_d    = state_q;
    ch_d       = ch_q;
    mode_d     = mode_q;
    fill_idx_d = fill_idx_q;
    q_d        = q_q;
    div_cnt_d  = div_cnt_q;
    rem_d      = rem_q;
    den_d      = den_q;
    quo_d      = quo_q;
    x_d        = x_q;
    idx_d      = idx_q;
    frac_d     = frac_q;
    sat_d      = sat_q;
    t0_d       = t0_q;
    g_d        = g_q;
    acc_d      = acc_q;
    tone_d     = tone_q;
    res_d      = res_q;
    m_tdata_d  = m_tdata_q;
    m_tvalid_d = m_tvalid_q;
    mul_a      = '0;
    mul_b      = '0;
    ram_we     = 1'b0;
    ram_waddr  = fill_idx_q;
    ram_wdata  = quo_q;
    ram_raddr  = idx_q;
    s_ready    = 1'b0;
    out_load   = 1'b0;

    if (m_tvalid_q && m_axis_tready_i) begin
      m_tvalid_d = 1'b0;
    end

    case (state_q)
      ST_F_SETUP: begin
        rem_d     = {1'b0, 32'h8000_0000 - q_q};
        den_d     = {1'b0, 32'h8000_0000} + {1'b0, q_q};
        quo_d     = '0;
        div_cnt_d = '0;
        state_d   = ST_F_DIV;
      end
      ST_F_DIV: begin
        rem_d     = div_ge ? (rem_sh - den_q) : rem_sh;
        quo_d     = {quo_q[TW-2:0], div_ge};
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == CNT_W'(TW - 1)) begin
          state_d = ST_F_WRITE;
        end
      end
      ST_F_WRITE: begin
        ram_we = 1'b1;
        mul_a  = {1'b0, q_q};
        mul_b  = {1'b0, ExpRatio};
        if (fill_idx_q == LastAddr) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_F_UPD;
        end
      end
      ST_F_UPD: begin
        q_d        = prod_q[62:31];
        fill_idx_d = fill_idx_q + 1'b1;
        state_d    = ST_F_SETUP;
      end
      ST_IDLE: begin
        s_ready = 1'b1;
        if (s_axis_tvalid_i) begin
          x_d[0]  = s_axis_tdata_i[SB-1:0];
          x_d[1]  = s_axis_tdata_i[2*SB-1:SB];
          mode_d  = cfg_mode_q;
          ch_d    = (cfg_mode_q == MODE_RIGHT);
          state_d = ST_GN;
        end
      end
      ST_GN: begin
        mul_a   = {{(MUL_W-GAIN_W){1'b0}}, cfg_gain_q};
        mul_b   = MUL_W'(TANH_TABLE_ENTRIES);
        state_d = ST_POS;
      end
      ST_POS: begin
        mul_a   = {{(MUL_W-SB){1'b0}}, x_abs};
        mul_b   = {1'b0, prod_q[31:0]};
        state_d = ST_IDX;
      end
      ST_IDX: begin
        sat_d     = pos_sat;
        idx_d     = pos_int[AW-1:0];
        frac_d    = pos_sat ? 16'd0 : prod_q[FRAC_LSB +: 16];
        ram_raddr = pos_sat ? LastAddr : pos_int[AW-1:0];
        state_d   = ST_RD0;
      end
      ST_RD0: begin
        t0_d      = ram_rdata;
        ram_raddr = sat_q ? LastAddr : (idx_q + 1'b1);
        state_d   = ST_RD1;
      end
      ST_RD1: begin
        mul_a   = {{(MUL_W-TW){1'b0}}, tap_diff};
        mul_b   = {{(MUL_W-16){1'b0}}, frac_q};
        state_d = ST_GATE;
      end
      ST_GATE: begin
        g_d     = g_val;
        state_d = ST_MULG;
      end
      ST_MULG: begin
        mul_a   = {g_q[31], g_q};
        mul_b   = {{(MUL_W-VOL_W){1'b0}}, alpha_c};
        state_d = ST_MULS;
      end
      ST_MULS: begin
        acc_d   = prod_q;
        mul_a   = {tone_q[ch_q][31], tone_q[ch_q]};
        mul_b   = {{(MUL_W-ALPHA_W){1'b0}}, cfg_alpha_q};
        state_d = ST_FILT;
      end
      ST_FILT: begin
        tone_d[ch_q] = filt_sum[47:16];
        state_d      = ST_MULV;
      end
      ST_MULV: begin
        mul_a   = {tone_q[ch_q][31], tone_q[ch_q]};
        mul_b   = {{(MUL_W-VOL_W){1'b0}}, vol_eff};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_d[ch_q] = prod_q[47:16+EB];
        if ((mode_q != MODE_LEFT) && (mode_q != MODE_RIGHT) && !ch_q) begin
          ch_d    = 1'b1;
          state_d = ST_GN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid_q || m_axis_tready_i) begin
          out_load   = 1'b1;
          m_tvalid_d = 1'b1;
          m_tdata_d  = '0;
          case (mode_q)
            MODE_LEFT: begin
              m_tdata_d[SB-1:0]    = res_q[0];
              m_tdata_d[2*SB-1:SB] = res_q[0];
            end
            MODE_RIGHT: begin
              m_tdata_d[SB-1:0]    = res_q[1];
              m_tdata_d[2*SB-1:SB] = res_q[1];
            end
            default: begin
              m_tdata_d[SB-1:0]    = res_q[0];
              m_tdata_d[2*SB-1:SB] = res_q[1];
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_F_SETUP;
      ch_q        <= 1'b0;
      mode_q      <= MODE_BOTH;
      fill_idx_q  <= '0;
      q_q         <= 32'h8000_0000;
      div_cnt_q   <= '0;
      m_tvalid_q  <= 1'b0;
      tone_q[0]   <= '0;
      tone_q[1]   <= '0;
      cfg_gain_q  <= GAIN_RST;
      cfg_thr_q   <= THR_RST;
      cfg_alpha_q <= ALPHA_RST;
      cfg_vol_q   <= VOL_RST;
      cfg_mode_q  <= MODE_BOTH;
    end else begin
      state_q    <= state_d;
      ch_q       <= ch_d;
      mode_q     <= mode_d;
      fill_idx_q <= fill_idx_d;
      q_q        <= q_d;
      div_cnt_q  <= div_cnt_d;
      m_tvalid_q <= m_tvalid_d;
      tone_q     <= tone_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DRIVE_GAIN:     cfg_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
          REG_GATE_THRESHOLD: cfg_thr_q   <= cfg_wdata_i[THR_W-1:0];
          REG_TONE_ALPHA:     cfg_alpha_q <= cfg_wdata_i[ALPHA_W-1:0];
          REG_OUT_VOLUME:     cfg_vol_q   <= cfg_wdata_i[VOL_W-1:0];
          REG_CHANNEL_MODE:   cfg_mode_q  <= cfg_wdata_i[MODE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers; the multiplier output is registered every cycle.
  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    rem_q     <= rem_d;
    den_q     <= den_d;
    quo_q     <= quo_d;
    x_q       <= x_d;
    idx_q     <= idx_d;
    frac_q    <= frac_d;
    sat_q     <= sat_d;
    t0_q      <= t0_d;
    g_q       <= g_d;
    acc_q     <= acc_d;
    res_q     <= res_d;
    m_tdata_q <= m_tdata_d;
  end

  assign s_axis_tready_o = s_ready;
  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

`ifndef SYNTH
  // The table rises monotonically, so the upper interpolation tap can never
  // be smaller than the lower one; a wrong read address would break this.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD1) |-> (ram_rdata >= t0_q))
    else $error("upper tanh tap below lower tap");

  // In the single-channel modes both output samples carry the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ((mode_q == MODE_LEFT) || (mode_q == MODE_RIGHT))) |=>
    (m_axis_tdata_o[SB-1:0] == m_axis_tdata_o[2*SB-1:SB]))
    else $error("single-channel frame has differing samples");

  // Right-only frames must leave the left filter state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) && (mode_q == MODE_RIGHT)) |=> $stable(tone_q[0]))
    else $error("left filter state changed in right-only mode");

  // Left-only frames must leave the right filter state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != ST_IDLE) && (mode_q == MODE_LEFT)) |=> $stable(tone_q[1]))
    else $error("right filter state changed in left-only mode");
`endif

endmodule

`default_nettype wire
